// ----- src/pah_pkg.sv -----
`default_nettype none

package pah_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_PANCAKES = 16;
   localparam int DEF_HASH_WIDTH   = 26;

   // fixed field widths
   localparam int PANCAKE_WIDTH = 5;
   localparam int COUNT_WIDTH   = 5;
   localparam int KIND_WIDTH    = 2;
   localparam int CSR_IDX_WIDTH = 1;

   // register reset values
   localparam int DEF_MODULUS = 4000039;
   localparam int DEF_COUNT   = 16;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODULUS = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COUNT   = 1'b1;

   // request kinds carried in req_tuser
   typedef enum logic [KIND_WIDTH-1:0] {
      REQ_LOAD = 2'd0,
      REQ_SEQ  = 2'd1,
      REQ_FLIP = 2'd2
   } req_kind_type;

   // what the second stage does with a transaction
   typedef enum logic [1:0] {
      OP_PLAIN = 2'd0,   // no hash: zeros, error flag as decoded
      OP_SEQ   = 2'd1,   // sequence element, accumulate into running hash
      OP_FLIP  = 2'd2,   // incremental flip update
      OP_PASS  = 2'd3    // whole-stack flip, old hash returned
   } stage_op_type;

endpackage

`default_nettype wire

// ----- src/pancake_adjacency_hash.sv -----
// Pipeline: an accepted request fills the stage-one register and the registered
//   pair-table read; the modular add then loads the output register. One transaction
//   per cycle unless rsp_tready stalls; the pair-table RAM reads two words per cycle.
// Reset: synchronous, active high; clears handshake state, running hash, position
//   count and previous pancake, and loads the register defaults. The pair table is
//   not cleared: each entry is undefined until loaded.
`default_nettype none

module pancake_adjacency_hash
   import pah_pkg::*;
#(
   parameter int MAX_PANCAKES = DEF_MAX_PANCAKES,
   parameter int HASH_WIDTH   = DEF_HASH_WIDTH,
   // derived, not meant to be overridden
   parameter int IN_BITS  = 7 * PANCAKE_WIDTH + 2 * HASH_WIDTH,
   parameter int IN_DW    = ((IN_BITS + 7) / 8) * 8,
   parameter int OUT_DW   = ((HASH_WIDTH + 7) / 8) * 8
) (
   input  wire                       clock,
   input  wire                       reset,
   // configuration writes
   input  wire                       csr_we,
   input  wire [CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire [HASH_WIDTH-1:0]      csr_wdata,
   // request stream
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // tdata, low to high: row_pancake, col_pancake, pair_word, seq_pancake,
   //   top_pancake, flip_pancake, below_pancake, flip_position, old_hash, zero pad
   input  wire [IN_DW-1:0]           req_tdata,
   // tuser: req_type
   input  wire [KIND_WIDTH-1:0]      req_tuser,
   // response stream
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // tdata, low to high: result hash, zero pad
   output logic [OUT_DW-1:0]         rsp_tdata,
   // tuser, low to high: hash_valid, range_error
   output logic [1:0]                rsp_tuser
);

   localparam int HW    = HASH_WIDTH;
   localparam int PW    = PANCAKE_WIDTH;
   localparam int AW    = $clog2(MAX_PANCAKES * MAX_PANCAKES);
   localparam int NW0   = $clog2(MAX_PANCAKES + 1);
   localparam int NW    = (NW0 > COUNT_WIDTH) ? NW0 : COUNT_WIDTH;

   // field offsets in req_tdata
   localparam int O_ROW   = 0;
   localparam int O_COL   = O_ROW + PW;
   localparam int O_WORD  = O_COL + PW;
   localparam int O_SEQ   = O_WORD + HW;
   localparam int O_TOP   = O_SEQ + PW;
   localparam int O_FLIP  = O_TOP + PW;
   localparam int O_BELOW = O_FLIP + PW;
   localparam int O_POS   = O_BELOW + PW;
   localparam int O_OLD   = O_POS + PW;

   // unpacked request fields
   logic [PW-1:0] row_pancake, col_pancake, seq_pancake;
   logic [PW-1:0] top_pancake, flip_pancake, below_pancake, flip_position;
   logic [HW-1:0] pair_word, old_hash;

   assign row_pancake   = req_tdata[O_ROW   +: PW];
   assign col_pancake   = req_tdata[O_COL   +: PW];
   assign pair_word     = req_tdata[O_WORD  +: HW];
   assign seq_pancake   = req_tdata[O_SEQ   +: PW];
   assign top_pancake   = req_tdata[O_TOP   +: PW];
   assign flip_pancake  = req_tdata[O_FLIP  +: PW];
   assign below_pancake = req_tdata[O_BELOW +: PW];
   assign flip_position = req_tdata[O_POS   +: PW];
   assign old_hash      = req_tdata[O_OLD   +: HW];

   // ---------------------------------------------------------------- registers
   logic [HW-1:0]          modulus_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= HW'(DEF_MODULUS);
         count_ff   <= COUNT_WIDTH'(DEF_COUNT);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata;
            CSR_COUNT:   count_ff   <= csr_wdata[COUNT_WIDTH-1:0];
            default:     ;
         endcase
      end
   end

   // effective count, saturated to 2..MAX_PANCAKES
   logic [NW-1:0] n_eff;

   always_comb begin
      n_eff = NW'(count_ff);
      if (n_eff < NW'(2)) begin
         n_eff = NW'(2);
      end else if (n_eff > NW'(MAX_PANCAKES)) begin
         n_eff = NW'(MAX_PANCAKES);
      end
   end

   function automatic logic in_n(input logic [PW-1:0] p, input logic [NW-1:0] n);
      in_n = (p != '0) && (NW'(p) <= n);
   endfunction

   // table address of pair (a, b), both counted from one
   function automatic logic [AW-1:0] pair_addr(input logic [PW-1:0] a,
                                                input logic [PW-1:0] b);
      logic [AW-1:0] ai, bi;
      ai = AW'(a) - AW'(1);
      bi = AW'(b) - AW'(1);
      pair_addr = AW'(ai * AW'(MAX_PANCAKES)) + bi;
   endfunction

   // ---------------------------------------------------------------- handshake
   logic s1_vld_ff, s1_vld_in;
   logic out_vld_ff, out_vld_in;
   logic rsp_free, req_acc, s1_move;

   assign rsp_free   = !out_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || rsp_free;
   assign req_acc    = req_tvalid && req_tready;
   assign s1_move    = s1_vld_ff && rsp_free;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_acc) begin
         s1_vld_in = 1'b1;
      end else if (rsp_free) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = rsp_free ? s1_vld_ff : out_vld_ff;
   end

   // ---------------------------------------------------------------- decode stage
   logic [COUNT_WIDTH-1:0] pos_cnt_ff, pos_cnt_in;
   logic [PW-1:0]          prev_ff, prev_in;

   stage_op_type    op_s0;
   logic            err_s0, restart_s0, add_s0, done_s0;
   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
   logic [COUNT_WIDTH-1:0] cnt_next;

   always_comb begin
      op_s0       = OP_PLAIN;
      err_s0      = 1'b0;
      restart_s0  = 1'b0;
      add_s0      = 1'b0;
      done_s0     = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      pos_cnt_in  = pos_cnt_ff;
      prev_in     = prev_ff;
      cnt_next    = pos_cnt_ff + COUNT_WIDTH'(1);
      ram_waddr   = pair_addr(row_pancake, col_pancake);
      ram_raddr_a = pair_addr(prev_ff, seq_pancake);
      ram_raddr_b = pair_addr(top_pancake, below_pancake);

      case (req_tuser)
         REQ_LOAD: begin
            if (in_n(row_pancake, n_eff) && in_n(col_pancake, n_eff)) begin
               ram_we = req_acc;
            end else begin
               err_s0 = 1'b1;
            end
         end
         REQ_SEQ: begin
            if (in_n(seq_pancake, n_eff)) begin
               op_s0      = OP_SEQ;
               ram_re     = req_acc;
               restart_s0 = (pos_cnt_ff == '0);
               // previous pancake is zero only before the first element after reset
               add_s0     = !restart_s0 && (prev_ff != '0) &&
                            (NW'(prev_ff) <= NW'(MAX_PANCAKES));
               done_s0    = (NW'(cnt_next) >= n_eff);
               prev_in    = seq_pancake;
               pos_cnt_in = done_s0 ? '0 : cnt_next;
            end else begin
               err_s0 = 1'b1;
            end
         end
         REQ_FLIP: begin
            ram_raddr_a = pair_addr(flip_pancake, below_pancake);
            if (!in_n(top_pancake, n_eff) || !in_n(flip_pancake, n_eff) ||
                !in_n(flip_position, n_eff)) begin
               err_s0 = 1'b1;
            end else if (NW'(flip_position) == n_eff) begin
               op_s0 = OP_PASS;
            end else if (!in_n(below_pancake, n_eff)) begin
               err_s0 = 1'b1;
            end else begin
               op_s0  = OP_FLIP;
               ram_re = req_acc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_cnt_ff <= '0;
         prev_ff    <= '0;
      end else if (req_acc) begin
         pos_cnt_ff <= pos_cnt_in;
         prev_ff    <= prev_in;
      end
   end

   // pair table, written by loads at accept, read for sequence and flip items
   logic [HW-1:0] word_a, word_b;

   pah_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_PANCAKES * MAX_PANCAKES)
   ) u_pair_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (pair_word),
      .re      (ram_re),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (word_a),
      .rdata_b (word_b)
   );

   // stage-one payload
   stage_op_type  s1_op_ff;
   logic          s1_err_ff, s1_restart_ff, s1_add_ff, s1_done_ff;
   logic [HW-1:0] s1_old_ff;
   logic [HW:0]   s1_oldm_ff;   // old hash plus modulus, wrap branch of the subtract

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff      <= op_s0;
         s1_err_ff     <= err_s0;
         s1_restart_ff <= restart_s0;
         s1_add_ff     <= add_s0;
         s1_done_ff    <= done_s0;
         s1_old_ff     <= old_hash;
         s1_oldm_ff    <= {1'b0, old_hash} + {1'b0, modulus_ff};
      end
   end

   // ---------------------------------------------------------------- hash stage
   logic [HW-1:0] run_hash_ff, run_hash_in;
   logic [HW:0]   seq_sum, flip_d1, flip_d2, flip_sum;
   logic [HW-1:0] seq_red, flip_diff, flip_red;
   logic          flip_gt;
   logic [HW-1:0] hash_in;
   logic          hvalid_in, herr_in;

   always_comb begin
      // sequence: one add and one conditional subtract
      seq_sum = {1'b0, run_hash_ff} + {1'b0, word_a};
      seq_red = (seq_sum >= {1'b0, modulus_ff}) ?
                HW'(seq_sum - {1'b0, modulus_ff}) : HW'(seq_sum);

      run_hash_in = run_hash_ff;
      if (s1_restart_ff) begin
         run_hash_in = '0;
      end else if (s1_add_ff) begin
         run_hash_in = seq_red;
      end

      // flip: drop the broken pair word, add the new one
      flip_d1   = {1'b0, s1_old_ff} - {1'b0, word_a};
      flip_d2   = s1_oldm_ff - {1'b0, word_a};
      flip_gt   = !flip_d1[HW] && (flip_d1 != '0);
      flip_diff = flip_gt ? flip_d1[HW-1:0] : flip_d2[HW-1:0];
      flip_sum  = {1'b0, flip_diff} + {1'b0, word_b};
      flip_red  = (flip_sum >= {1'b0, modulus_ff}) ?
                  HW'(flip_sum - {1'b0, modulus_ff}) : HW'(flip_sum);

      hash_in   = '0;
      hvalid_in = 1'b0;
      herr_in   = 1'b0;
      case (s1_op_ff)
         OP_PLAIN: herr_in = s1_err_ff;
         OP_SEQ: begin
            if (s1_done_ff) begin
               hash_in   = run_hash_in;
               hvalid_in = 1'b1;
            end
         end
         OP_FLIP: begin
            hash_in   = flip_red;
            hvalid_in = 1'b1;
         end
         OP_PASS: begin
            hash_in   = s1_old_ff;
            hvalid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_hash_ff <= '0;
      end else if (s1_move && (s1_op_ff == OP_SEQ)) begin
         run_hash_ff <= run_hash_in;
      end
   end

   // ---------------------------------------------------------------- output register
   logic [HW-1:0] out_hash_ff;
   logic          out_hvalid_ff, out_herr_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_hash_ff   <= hash_in;
         out_hvalid_ff <= hvalid_in;
         out_herr_ff   <= herr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OUT_DW'(out_hash_ff);
   assign rsp_tuser  = {out_herr_ff, out_hvalid_ff};

   // ---------------------------------------------------------------- assertions
   a_valid_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("response flags both hash_valid and range_error");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (out_hash_ff == '0))
      else $error("hash nonzero on a response without a hash");

   a_ram_rw_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("pair table written and read by the same transaction");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (op_s0 == OP_SEQ) && done_s0) |=> (pos_cnt_ff == '0))
      else $error("position count not restarted after a finished sequence");

endmodule

`default_nettype wire

// ----- src/pah_ram.sv -----
`default_nettype none

module pah_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 256
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire [$clog2(DEPTH)-1:0]   waddr,
   input  wire [WIDTH-1:0]           wdata,
   input  wire                       re,
   input  wire [$clog2(DEPTH)-1:0]   raddr_a,
   input  wire [$clog2(DEPTH)-1:0]   raddr_b,
   output logic [WIDTH-1:0]          rdata_a,
   output logic [WIDTH-1:0]          rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem_ff[raddr_a];
         rdata_b <= mem_ff[raddr_b];
      end
   end

endmodule

`default_nettype wire
